/* rtl/core/nca_pkg.sv */
// Shared types and constants for the nearest-center assignment block.
package nca_pkg;

  localparam int DEF_MAX_CENTERS  = 16;
  localparam int DEF_MAX_FEATURES = 64;

  localparam int SUM_W = 48;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam int CFG_DATA_W = 7;

  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = 2;
  localparam int CMD_CNT_W = 3;

  typedef enum logic {
    OP_LOAD     = 1'b0,
    OP_CLASSIFY = 1'b1
  } op_e;

  typedef enum logic {
    CFG_CLUSTERS = 1'b0,
    CFG_FEATURES = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    op_e                operation;
    logic [3:0]         center_index;
    logic [5:0]         feature_index;
    logic signed [15:0] feature_value;
  } in_item_t;

  typedef struct packed {
    logic [3:0]       best_center;
    logic [SUM_W-1:0] best_distance;
  } out_item_t;

  // Decoded work for the back end.
  typedef struct packed {
    logic               is_load;
    logic               first;
    logic               last;
    logic [3:0]         center;
    logic [5:0]         feature;
    logic signed [15:0] value;
  } cmd_t;

endpackage

/* rtl/core/nca_front.sv */
// Front end: configuration registers and decoding of incoming transactions.
module nca_front import nca_pkg::*; #(
  parameter int MAX_CENTERS  = DEF_MAX_CENTERS,
  parameter int MAX_FEATURES = DEF_MAX_FEATURES,
  localparam int NCW = $clog2(MAX_CENTERS + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  cfg_reg_e              cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  in_item_t              item_i,
  output cmd_t                  cmd_o,
  output logic                  keep_o,
  output logic [NCW-1:0]        nc_o
);

  localparam int NFW = $clog2(MAX_FEATURES + 1);

  logic [4:0]     clusters_q;
  logic [6:0]     features_q;
  logic [NFW-1:0] nf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clusters_q <= 5'd1;
      features_q <= 7'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CLUSTERS: clusters_q <= cfg_data_i[4:0];
        CFG_FEATURES: features_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Register values outside the legal range are clamped where they are used.
  always_comb begin
    if (clusters_q == 5'd0) begin
      nc_o = NCW'(1);
    end else if (32'(clusters_q) > MAX_CENTERS) begin
      nc_o = NCW'(MAX_CENTERS);
    end else begin
      nc_o = NCW'(clusters_q);
    end
    if (features_q == 7'd0) begin
      nf = NFW'(1);
    end else if (32'(features_q) > MAX_FEATURES) begin
      nf = NFW'(MAX_FEATURES);
    end else begin
      nf = NFW'(features_q);
    end
  end

  always_comb begin
    cmd_o.is_load = (item_i.operation == OP_LOAD);
    cmd_o.center  = item_i.center_index;
    cmd_o.feature = item_i.feature_index;
    cmd_o.value   = item_i.feature_value;
    cmd_o.first   = 1'b0;
    cmd_o.last    = 1'b0;
    if (item_i.operation == OP_LOAD) begin
      keep_o = (32'(item_i.center_index) < MAX_CENTERS) &&
               (32'(item_i.feature_index) < MAX_FEATURES);
    end else begin
      keep_o      = 32'(item_i.feature_index) < 32'(nf);
      cmd_o.first = (item_i.feature_index == 6'd0);
      cmd_o.last  = 32'(item_i.feature_index) == 32'(nf) - 32'd1;
    end
  end

endmodule

/* rtl/core/nca_cmd_fifo.sv */
// Short command queue between the front end and the back end.
module nca_cmd_fifo import nca_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  cmd_t wr_data_i,
  output logic full_o,
  input  logic rd_i,
  output cmd_t rd_data_o,
  output logic empty_o
);

  cmd_t                 mem_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q;
  logic [CMD_PTR_W-1:0] rd_ptr_q;
  logic [CMD_CNT_W-1:0] count_q;

  assign full_o    = (count_q == CMD_CNT_W'(CMD_DEPTH));
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= wr_ptr_q + CMD_PTR_W'(1);
      end
      if (rd_i) begin
        rd_ptr_q <= rd_ptr_q + CMD_PTR_W'(1);
      end
      if (wr_i && !rd_i) begin
        count_q <= count_q + CMD_CNT_W'(1);
      end else if (rd_i && !wr_i) begin
        count_q <= count_q - CMD_CNT_W'(1);
      end
    end
  end

endmodule

/* rtl/core/nca_back.sv */
// Back end: center store, running distance sums and nearest-center search.
module nca_back import nca_pkg::*; #(
  parameter int MAX_CENTERS  = DEF_MAX_CENTERS,
  parameter int MAX_FEATURES = DEF_MAX_FEATURES,
  localparam int NCW = $clog2(MAX_CENTERS + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [NCW-1:0] nc_i,
  input  cmd_t           cmd_i,
  input  logic           cmd_valid_i,
  output logic           cmd_pop_o,
  output out_item_t      res_o,
  output logic           res_valid_o,
  input  logic           res_pop_i
);

  localparam int DEPTH = MAX_CENTERS * MAX_FEATURES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } back_state_e;

  back_state_e state_q, state_d;

  logic [15:0]      ctr_mem [DEPTH];
  logic [SUM_W-1:0] sum_mem [MAX_CENTERS];
  logic [MAX_CENTERS-1:0] sum_vld_q;

  // Feature being classified.
  logic [5:0]         cur_fi_q;
  logic signed [15:0] cur_x_q;
  logic               cur_first_q;
  logic               cur_last_q;
  logic [CW-1:0]      c_q;

  // Stage 1: memory read data.
  logic               s1_vld_q;
  logic [CW-1:0]      s1_c_q;
  logic signed [15:0] ctr_rd_q;
  logic [SUM_W-1:0]   sum_rd_q;
  logic               vld_rd_q;

  // Stage 2: squared difference and the old sum.
  logic               s2_vld_q;
  logic [CW-1:0]      s2_c_q;
  logic [31:0]        sq_q;
  logic [SUM_W-1:0]   base_q;

  logic [3:0]       best_c_q;
  logic [SUM_W-1:0] best_d_q;
  out_item_t        res_q;
  logic             res_valid_q;

  logic             issue;
  logic             issue_last;
  logic             load_wr;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    rd_addr;
  logic signed [16:0] diff;
  logic [15:0]      mag;
  logic [SUM_W:0]   total;
  logic [SUM_W-1:0] new_sum;
  logic             take;
  logic [3:0]       nxt_c;
  logic [SUM_W-1:0] nxt_d;
  logic             s2_final;

  // A closing feature waits until the result slot is free.
  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i &&
                     !(cmd_i.last && res_valid_q);
  assign load_wr    = cmd_pop_o && cmd_i.is_load;
  assign issue      = (state_q == ST_RUN);
  assign issue_last = 32'(c_q) == 32'(nc_i) - 32'd1;

  assign wr_addr = AW'(32'(cmd_i.center) * MAX_FEATURES + 32'(cmd_i.feature));
  assign rd_addr = AW'(32'(c_q) * MAX_FEATURES + 32'(cur_fi_q));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_pop_o && !cmd_i.is_load) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (issue_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_vld_q && !s2_vld_q) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_wr) begin
      ctr_mem[wr_addr] <= cmd_i.value;
    end
    if (issue) begin
      ctr_rd_q <= ctr_mem[rd_addr];
      sum_rd_q <= sum_mem[c_q];
      vld_rd_q <= sum_vld_q[c_q];
    end
    if (s2_vld_q) begin
      sum_mem[s2_c_q] <= new_sum;
    end
  end

  assign diff = 17'(cur_x_q) - 17'(ctr_rd_q);
  assign mag  = diff[16] ? 16'(-diff) : diff[15:0];

  assign total   = {1'b0, base_q} + (SUM_W + 1)'(sq_q);
  assign new_sum = total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];

  // Strictly smaller wins, so ties keep the lower center index.
  assign take     = (s2_c_q == '0) || (new_sum < best_d_q);
  assign nxt_c    = take ? 4'(s2_c_q) : best_c_q;
  assign nxt_d    = take ? new_sum : best_d_q;
  assign s2_final = s2_vld_q && cur_last_q && (32'(s2_c_q) == 32'(nc_i) - 32'd1);

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && !cmd_i.is_load) begin
      cur_fi_q    <= cmd_i.feature;
      cur_x_q     <= cmd_i.value;
      cur_first_q <= cmd_i.first;
      cur_last_q  <= cmd_i.last;
    end
    if (issue) begin
      s1_c_q <= c_q;
    end
    if (s1_vld_q) begin
      s2_c_q <= s1_c_q;
      sq_q   <= 32'(mag) * 32'(mag);
      base_q <= (cur_first_q || !vld_rd_q) ? '0 : sum_rd_q;
    end
    if (s2_vld_q && cur_last_q) begin
      best_c_q <= nxt_c;
      best_d_q <= nxt_d;
    end
    if (s2_final) begin
      res_q.best_center   <= nxt_c;
      res_q.best_distance <= nxt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      c_q         <= '0;
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      sum_vld_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      s1_vld_q <= issue;
      s2_vld_q <= s1_vld_q;
      if (cmd_pop_o && !cmd_i.is_load) begin
        c_q <= '0;
        // A new sample starts every sum from zero.
        if (cmd_i.first) begin
          sum_vld_q <= '0;
        end
      end else if (issue && !issue_last) begin
        c_q <= c_q + CW'(1);
      end
      if (s2_vld_q) begin
        sum_vld_q[s2_c_q] <= 1'b1;
      end
      if (res_pop_i && res_valid_q) begin
        res_valid_q <= 1'b0;
      end
      if (s2_final) begin
        res_valid_q <= 1'b1;
      end
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

endmodule

/* rtl/core/nearest_center_assign.sv */
// Decoded transactions queue up to four deep ahead of the back end.
// A load is written in the idle state; a classify feature visits N centers, N the clamped
// cluster count, one a cycle on the single shared squaring multiplier, then drains.
// A result passes the read and square stages, then a register, and is held until popped.
// Reset is asynchronous and active low: both counts return to 1 and all sums read as zero.
// The center store is not cleared; no clearing pass is needed.
module nearest_center_assign import nca_pkg::*; #(
  parameter int MAX_CENTERS  = DEF_MAX_CENTERS,
  parameter int MAX_FEATURES = DEF_MAX_FEATURES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  cfg_reg_e              cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  push,
  output logic                  full,
  input  in_item_t              in_item_i,
  output logic                  empty,
  input  logic                  pop,
  output out_item_t             out_item_o
);

  localparam int NCW = $clog2(MAX_CENTERS + 1);

  cmd_t           front_cmd;
  logic           front_keep;
  logic [NCW-1:0] nc;
  cmd_t           q_cmd;
  logic           q_empty;
  logic           q_pop;
  logic           res_valid;

  nca_front #(
    .MAX_CENTERS  (MAX_CENTERS),
    .MAX_FEATURES (MAX_FEATURES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (in_item_i),
    .cmd_o       (front_cmd),
    .keep_o      (front_keep),
    .nc_o        (nc)
  );

  // Transactions that do nothing are accepted and dropped here.
  nca_cmd_fifo u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (push && !full && front_keep),
    .wr_data_i (front_cmd),
    .full_o    (full),
    .rd_i      (q_pop),
    .rd_data_o (q_cmd),
    .empty_o   (q_empty)
  );

  nca_back #(
    .MAX_CENTERS  (MAX_CENTERS),
    .MAX_FEATURES (MAX_FEATURES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .nc_i        (nc),
    .cmd_i       (q_cmd),
    .cmd_valid_i (!q_empty),
    .cmd_pop_o   (q_pop),
    .res_o       (out_item_o),
    .res_valid_o (res_valid),
    .res_pop_i   (pop)
  );

  assign empty = !res_valid;

endmodule

/* tb/nca_label_check.sv */
// Checker for the nearest-center block: predicts each label and compares it on pop.
module nca_label_check import nca_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  cfg_reg_e              cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  push_i,
  input  logic                  full_i,
  input  in_item_t              in_item_i,
  input  logic                  empty_i,
  input  logic                  pop_i,
  input  out_item_t             out_item_i,
  output int                    errors_o,
  output int                    pending_o
);

  logic signed [15:0] center_mem [DEF_MAX_CENTERS*DEF_MAX_FEATURES];
  logic [SUM_W-1:0]   run_sum [DEF_MAX_CENTERS];
  logic [4:0]         clusters_reg;
  logic [6:0]         features_reg;
  out_item_t          label_q [$];
  int                 fail_total;

  // Applies one accepted input transaction to the predicted state.
  task automatic score_feature(input in_item_t it);
    int unsigned      nc;
    int unsigned      nf;
    int unsigned      fi;
    int               diff;
    longint unsigned  mag;
    longint unsigned  total;
    out_item_t        label;
    fi = 32'(it.feature_index);
    if (it.operation == OP_LOAD) begin
      center_mem[it.center_index*DEF_MAX_FEATURES + fi] = it.feature_value;
    end else begin
      nc = (clusters_reg == 5'd0) ? 1 : 32'(clusters_reg);
      if (nc > DEF_MAX_CENTERS) nc = DEF_MAX_CENTERS;
      nf = (features_reg == 7'd0) ? 1 : 32'(features_reg);
      if (nf > DEF_MAX_FEATURES) nf = DEF_MAX_FEATURES;
      if (fi < nf) begin
        if (fi == 0) begin
          foreach (run_sum[c]) run_sum[c] = '0;
        end
        for (int c = 0; c < nc; c++) begin
          diff = int'($signed(it.feature_value))
               - int'($signed(center_mem[c*DEF_MAX_FEATURES + fi]));
          mag = 64'((diff < 0) ? -diff : diff);
          total = run_sum[c] + mag * mag;
          run_sum[c] = (total > SUM_MAX) ? SUM_MAX : total[SUM_W-1:0];
        end
        if (fi == nf - 1) begin
          // Only a strictly smaller sum displaces the current winner.
          label.best_center   = '0;
          label.best_distance = run_sum[0];
          for (int c = 1; c < nc; c++) begin
            if (run_sum[c] < label.best_distance) begin
              label.best_distance = run_sum[c];
              label.best_center   = c[3:0];
            end
          end
          label_q.push_back(label);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t want;
    if (!rst_ni) begin
      clusters_reg = 5'd1;
      features_reg = 7'd1;
      foreach (run_sum[c]) run_sum[c] = '0;
      foreach (center_mem[i]) center_mem[i] = '0;
      label_q.delete();
      fail_total = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_CLUSTERS) clusters_reg = cfg_data_i[4:0];
        else features_reg = cfg_data_i[6:0];
      end
      // A result popped at this edge predates any item pushed at it.
      if (pop_i && !empty_i) begin
        if (label_q.size() == 0) begin
          $error("unexpected result: best_center %0d best_distance %0d",
                 out_item_i.best_center, out_item_i.best_distance);
          fail_total++;
        end else begin
          want = label_q.pop_front();
          if (out_item_i.best_center !== want.best_center) begin
            $error("best_center: expected %0d, actual %0d",
                   want.best_center, out_item_i.best_center);
            fail_total++;
          end
          if (out_item_i.best_distance !== want.best_distance) begin
            $error("best_distance: expected %0d, actual %0d",
                   want.best_distance, out_item_i.best_distance);
            fail_total++;
          end
        end
      end
      if (push_i && !full_i) score_feature(in_item_i);
      errors_o  <= fail_total;
      pending_o <= label_q.size();
    end
  end

endmodule

/* tb/nearest_center_assign_tb.sv */
// Top of the nearest-center testbench: clock, reset, stimulus and the verdict.
module nearest_center_assign_tb;
  import nca_pkg::*;

  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 100;
  localparam int RANDOM_ITEMS  = 1500;
  localparam int PHASE_ITEMS   = 200;
  localparam int TAIL_ITEMS    = 40;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_reg_e              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  push;
  logic                  full;
  in_item_t              in_item;
  logic                  empty;
  logic                  pop;
  out_item_t             out_item;

  int errors;
  int pending;
  int idle_pct;
  int pop_hold;
  int stall_cycles;
  int items_sent;
  int active_nc;
  int active_nf;
  bit loaded [DEF_MAX_CENTERS][DEF_MAX_FEATURES];

  nearest_center_assign DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item)
  );

  nca_label_check label_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .push_i      (push),
    .full_i      (full),
    .in_item_i   (in_item),
    .empty_i     (empty),
    .pop_i       (pop),
    .out_item_i  (out_item),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The result side stalls in bursts of random length while idle_pct is nonzero.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (pop_hold > 0) begin
      pop_hold--;
      pop <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      pop_hold = $urandom_range(0, 10);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int clamp_count(int raw, int hi);
    if (raw < 1) return 1;
    if (raw > hi) return hi;
    return raw;
  endfunction

  function automatic logic [15:0] pick_feature();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_item(op_e op, int ci, int fi, logic [15:0] value);
    in_item_t it;
    it.operation     = op;
    it.center_index  = ci[3:0];
    it.feature_index = fi[5:0];
    it.feature_value = value;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    if (op == OP_LOAD) loaded[ci][fi] = 1'b1;
    if (op == OP_LOAD || fi < active_nf) items_sent++;
  endtask

  // Loads any center entry this feature would read before it was ever written.
  task automatic classify(int fi, logic [15:0] value);
    if (fi < active_nf) begin
      for (int c = 0; c < active_nc; c++) begin
        if (!loaded[c][fi]) push_item(OP_LOAD, c, fi, pick_feature());
      end
    end
    push_item(OP_CLASSIFY, $urandom_range(0, 15), fi, value);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Call only while the block is idle.
  task automatic set_config(int nc_raw, int nf_raw);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CLUSTERS;
    cfg_data  <= nc_raw[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= CFG_FEATURES;
    cfg_data  <= nf_raw[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    active_nc = clamp_count(nc_raw & 'h1F, DEF_MAX_CENTERS);
    active_nf = clamp_count(nf_raw & 'h7F, DEF_MAX_FEATURES);
  endtask

  task automatic run_random_phase(int quota);
    int stop_at;
    int pick;
    int first;
    int last;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        for (int f = 0; f < active_nf; f++) classify(f, pick_feature());
      end else if (pick < 88) begin
        push_item(OP_LOAD, $urandom_range(0, 15), $urandom_range(0, 63), pick_feature());
      end else if (pick < 94 && active_nf < DEF_MAX_FEATURES) begin
        push_item(OP_CLASSIFY, $urandom_range(0, 15),
                  $urandom_range(active_nf, DEF_MAX_FEATURES - 1), pick_feature());
      end else begin
        // Broken sample: it may start late, stop early, or both.
        first = $urandom_range(0, active_nf - 1);
        last  = $urandom_range(first, active_nf - 1);
        for (int f = first; f <= last; f++) classify(f, pick_feature());
      end
    end
  endtask

  initial begin
    int phase;
    int rand_start;
    int nc_raw;
    int nf_raw;
    clk          = 1'b0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_CLUSTERS;
    cfg_data     = '0;
    push         = 1'b0;
    pop          = 1'b0;
    in_item      = '0;
    idle_pct     = 0;
    pop_hold     = 0;
    stall_cycles = 0;
    items_sent   = 0;
    active_nc    = 1;
    active_nf    = 1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: one center, one feature.
    idle_pct = 25;
    push_item(OP_LOAD, 0, 0, 16'h8000);
    classify(0, 16'h7FFF);
    classify(0, 16'h8000);
    push_item(OP_CLASSIFY, 15, 63, 16'h1234);
    push_item(OP_LOAD, 15, 63, 16'h7FFF);
    drain();

    // Zero counts clamp up to one.
    set_config(0, 0);
    classify(0, 16'h0100);
    drain();

    // Oversized counts clamp to the maximum; a sample that skips feature zero keeps adding.
    set_config('h7F, 'h7F);
    classify(63, 16'h7FFF);
    drain();

    // Ties go to the lower index.
    set_config(3, 2);
    for (int c = 0; c < 3; c++) begin
      push_item(OP_LOAD, c, 0, 16'h0200);
      push_item(OP_LOAD, c, 1, 16'h0200);
    end
    classify(0, 16'h0100);
    classify(1, 16'h0100);
    push_item(OP_LOAD, 2, 0, 16'h0100);
    classify(0, 16'h0100);
    classify(1, 16'h0100);
    push_item(OP_LOAD, 1, 0, 16'h0100);
    classify(0, 16'h0100);
    classify(1, 16'h0100);
    drain();

    rand_start = items_sent;
    phase = 0;
    while (items_sent - rand_start < RANDOM_ITEMS) begin
      if (phase == 0) begin
        nc_raw = DEF_MAX_CENTERS;
        nf_raw = DEF_MAX_FEATURES;
      end else if (phase == 1) begin
        nc_raw = 1;
        nf_raw = 1;
      end else begin
        nc_raw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                             : $urandom_range(1, DEF_MAX_CENTERS);
        case ($urandom_range(0, 9))
          0:       nf_raw = $urandom_range(0, 127);
          1, 2:    nf_raw = $urandom_range(1, DEF_MAX_FEATURES);
          default: nf_raw = $urandom_range(1, 8);
        endcase
      end
      set_config(nc_raw, nf_raw);
      case ($urandom_range(0, 3))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        2:       idle_pct = 30;
        default: idle_pct = 60;
      endcase
      run_random_phase(PHASE_ITEMS);
      drain();
      phase++;
    end

    // A long sample without restarts and without idling: the last feature keeps
    // adding the largest square to both sums, and center 1 stays ahead.
    idle_pct = 0;
    drain();
    set_config(2, 2);
    push_item(OP_LOAD, 0, 0, 16'h8000);
    push_item(OP_LOAD, 1, 0, 16'h0000);
    push_item(OP_LOAD, 0, 1, 16'h8000);
    push_item(OP_LOAD, 1, 1, 16'h8000);
    classify(0, 16'h7FFF);
    repeat (TAIL_ITEMS) classify(1, 16'h7FFF);
    drain();

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/nca_pkg.sv
rtl/core/nca_front.sv
rtl/core/nca_cmd_fifo.sv
rtl/core/nca_back.sv
rtl/core/nearest_center_assign.sv
tb/nca_label_check.sv
tb/nearest_center_assign_tb.sv
